[design/stg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper step generator package
// Sequencer states, profile phases, register indexes, field widths and the
// fixed constants of the step generator.
// ----------------------------------------------------------------------------
package stg_pkg;

   // Sequencer states
   typedef enum logic [3:0] {
      S_READY,
      S_CMD,
      S_CMD2,
      S_PHASE,
      S_LOAD,
      S_SCALE,
      S_DIVSET,
      S_DIV,
      S_FINISH
   } stg_state_type;

   // Motion profile phases
   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ACCEL,
      PH_CRUISE,
      PH_DECEL
   } stg_phase_type;

   // Register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SPEED   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONST_SPEED = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DELAY   = 2'd2;
   localparam int CSR_DATA_BITS = 24;

   // Field widths
   localparam int SPEED_BITS      = 16;
   localparam int TICK_BITS       = 20;
   localparam int TARGET_BITS     = 32;
   localparam int WIDE_BITS       = 64;
   localparam int REQ_TDATA_BITS  = 40;
   localparam int RSP_TDATA_BITS  = 40;

   // Ticks per second, dividend of the half-period divider
   localparam logic [TICK_BITS-1:0] TICKS_PER_SECOND = 20'd1000000;

   // Register reset values
   localparam logic [SPEED_BITS-1:0] RESET_MAX_SPEED   = 16'd1000;
   localparam logic [SPEED_BITS-1:0] RESET_CONST_SPEED = 16'd1000;
   localparam logic [31:0]           RESET_MAX_DELAY   = 32'd1000000;

   // Bit counter of the serial units
   localparam int CNT_BITS = 5;
   localparam logic [CNT_BITS-1:0] SCALE_LAST = 5'd15;
   localparam logic [CNT_BITS-1:0] DIV_LAST   = 5'd19;

endpackage

[design/stepper_trapezoid_step_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoidal step generator
// Drives step and direction levels toward an absolute target, one request
// (tick or move command) at a time, with a bit-serial speed scaler and a
// bit-serial half-period divider.
// ----------------------------------------------------------------------------
// Sequence: a tick that ends no step goes straight to the result; a tick
//   that ends a step runs S_PHASE when the phase changes, then S_LOAD, the
//   scaler on ramp steps and the divider; a move command runs S_CMD, S_CMD2 first.
// Throughput: one request at a time; the long cases are set by the bit-serial
//   speed scaler (one bit of max_speed a cycle) and the divider of
//   the half-period (one quotient bit a cycle).
// Reset: synchronous, active high; state and control registers return to
//   their defaults and the block is idle at position zero.
module stepper_trapezoid_step_generator #(
   parameter int POSITION_BITS = 32,
   parameter int DELAY_BITS    = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request: tdata = target_position[31:0], ramped[32], zero fill
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [stg_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // request: tuser = kind
   input  logic                                 req_tuser,
   // result: tdata = step_level[0], dir_level[1], position[33:2],
   //         busy_res[34], accepted[35], zero fill
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [stg_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [stg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [stg_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int QW        = POSITION_BITS - 2;
   localparam int WIDE_BITS = stg_pkg::WIDE_BITS;
   localparam int SPEED_W   = stg_pkg::SPEED_BITS;
   localparam int TICK_W    = stg_pkg::TICK_BITS;

   // Sequencer and profile state
   stg_pkg::stg_state_type state_ff, state_in;
   stg_pkg::stg_phase_type phase_ff, phase_in;
   logic                     pulse_ff, pulse_in;
   logic                     dir_ff, dir_in;
   logic                     ramp_ff, ramp_in;
   logic                     acc_ff, acc_in;
   logic [POSITION_BITS-1:0] cur_pos_ff, cur_pos_in;
   logic [POSITION_BITS-1:0] goal_ff, goal_in;
   logic [POSITION_BITS-1:0] steps_left_ff, steps_left_in;
   logic [POSITION_BITS-1:0] cruise_ff, cruise_in;
   logic [QW-1:0]            ramp_index_ff, ramp_index_in;
   logic [QW-1:0]            quarter_ff, quarter_in;
   logic [DELAY_BITS-1:0]    timer_ff, timer_in;
   logic [DELAY_BITS-1:0]    period_ff, period_in;

   // Configuration registers
   logic [SPEED_W-1:0]       max_speed_ff, max_speed_in;
   logic [SPEED_W-1:0]       const_speed_ff, const_speed_in;
   logic [DELAY_BITS-1:0]    max_delay_ff, max_delay_in;

   // Serial unit working registers
   logic [stg_pkg::CNT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [SPEED_W-1:0]       mult_ff, mult_in;
   logic [QW-1:0]            numer_ff, numer_in;
   logic [QW-1:0]            rem_ff, rem_in;
   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic [TICK_W-1:0]        div_ff, div_in;
   logic [SPEED_W-1:0]       hrem_ff, hrem_in;

   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [stg_pkg::RSP_TDATA_BITS-1:0]  rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic signed [WIDE_BITS-1:0] tgt_wide;
   logic [POSITION_BITS-1:0]    tgt_pos;
   logic signed [WIDE_BITS-1:0] pos_wide;
   logic [POSITION_BITS-1:0]    total;
   logic [DELAY_BITS:0]         tsum;
   logic [QW+1:0]               srem2;
   logic [QW+1:0]               sq1;
   logic [QW+1:0]               sq2;
   logic [QW+1:0]               srem_new;
   logic [1:0]                  sdigit;
   logic [SPEED_W:0]            hrem2;
   logic                        hbit;
   logic [SPEED_W:0]            hrem_new;
   logic [TICK_W-1:0]           quotient;
   logic [DELAY_BITS-1:0]       half_sat;
   logic [POSITION_BITS-1:0]    phase_count;
   stg_pkg::stg_phase_type      phase_next;
   logic                        phase_end;

   // Sign-extend the target and wrap it to the position width
   assign tgt_wide = WIDE_BITS'($signed(req_tdata[stg_pkg::TARGET_BITS-1:0]));
   assign tgt_pos  = tgt_wide[POSITION_BITS-1:0];
   assign pos_wide = WIDE_BITS'($signed(cur_pos_ff));

   // Distance still to travel
   assign total = dir_ff ? (goal_ff - cur_pos_ff) : (cur_pos_ff - goal_ff);

   // Half-period timer advance
   assign tsum = {1'b0, timer_ff} + (DELAY_BITS+1)'(1);

   // Speed scaler: one bit of max_speed a cycle, quotient digit 0..2
   always_comb begin
      srem2  = {1'b0, rem_ff, 1'b0} + (mult_ff[SPEED_W-1] ? (QW+2)'(numer_ff) : '0);
      sq1    = (QW+2)'(quarter_ff);
      sq2    = (QW+2)'({quarter_ff, 1'b0});
      if (srem2 >= sq2) begin
         srem_new = srem2 - sq2;
         sdigit   = 2'd2;
      end else if (srem2 >= sq1) begin
         srem_new = srem2 - sq1;
         sdigit   = 2'd1;
      end else begin
         srem_new = srem2;
         sdigit   = 2'd0;
      end
   end

   // Half-period divider: restoring, one quotient bit a cycle
   always_comb begin
      hrem2 = {hrem_ff, div_ff[TICK_W-1]};
      hbit  = (hrem2 >= {1'b0, speed_ff});
      hrem_new = hbit ? (hrem2 - {1'b0, speed_ff}) : hrem2;
      quotient = {div_ff[TICK_W-2:0], hbit};
      if (32'(quotient) > 32'(max_delay_ff)) begin
         half_sat = max_delay_ff;
      end else begin
         half_sat = DELAY_BITS'(quotient);
      end
   end

   // Next profile phase and its step count
   always_comb begin
      phase_next  = stg_pkg::PH_IDLE;
      phase_count = '0;
      phase_end   = 1'b0;
      unique case (phase_ff)
         stg_pkg::PH_IDLE: begin
            phase_next  = ramp_ff ? stg_pkg::PH_ACCEL : stg_pkg::PH_CRUISE;
            phase_count = ramp_ff ? POSITION_BITS'(quarter_ff) : cruise_ff;
         end
         stg_pkg::PH_ACCEL: begin
            phase_next  = stg_pkg::PH_CRUISE;
            phase_count = cruise_ff;
         end
         stg_pkg::PH_CRUISE: begin
            if (ramp_ff) begin
               phase_next  = stg_pkg::PH_DECEL;
               phase_count = POSITION_BITS'(quarter_ff);
            end else begin
               phase_end = 1'b1;
            end
         end
         stg_pkg::PH_DECEL: begin
            phase_end = 1'b1;
         end
         default: begin
            phase_end = 1'b1;
         end
      endcase
   end

   // Next state and datapath updates
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      pulse_in       = pulse_ff;
      dir_in         = dir_ff;
      ramp_in        = ramp_ff;
      acc_in         = acc_ff;
      cur_pos_in     = cur_pos_ff;
      goal_in        = goal_ff;
      steps_left_in  = steps_left_ff;
      cruise_in      = cruise_ff;
      ramp_index_in  = ramp_index_ff;
      quarter_in     = quarter_ff;
      timer_in       = timer_ff;
      period_in      = period_ff;
      max_speed_in   = max_speed_ff;
      const_speed_in = const_speed_ff;
      max_delay_in   = max_delay_ff;
      bit_cnt_in     = bit_cnt_ff;
      mult_in        = mult_ff;
      numer_in       = numer_ff;
      rem_in         = rem_ff;
      speed_in       = speed_ff;
      div_in         = div_ff;
      hrem_in        = hrem_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      req_tready     = (state_ff == stg_pkg::S_READY);
      csr_ready      = 1'b1;

      // Register writes
      if (csr_valid) begin
         unique case (csr_index)
            stg_pkg::CSR_MAX_SPEED:   max_speed_in   = csr_data[SPEED_W-1:0];
            stg_pkg::CSR_CONST_SPEED: const_speed_in = csr_data[SPEED_W-1:0];
            stg_pkg::CSR_MAX_DELAY:   max_delay_in   = DELAY_BITS'(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         stg_pkg::S_READY: begin
            if (req_tvalid) begin
               acc_in   = 1'b0;
               state_in = stg_pkg::S_FINISH;
               if (req_tuser) begin
                  // Take a move command only while idle
                  if (phase_ff == stg_pkg::PH_IDLE) begin
                     acc_in   = 1'b1;
                     dir_in   = ($signed(tgt_pos) > $signed(cur_pos_ff));
                     goal_in  = tgt_pos;
                     ramp_in  = req_tdata[stg_pkg::TARGET_BITS];
                     state_in = stg_pkg::S_CMD;
                  end
               end else if (phase_ff != stg_pkg::PH_IDLE) begin
                  // Advance the half-period timer
                  if (tsum >= {1'b0, period_ff}) begin
                     timer_in = '0;
                     if (pulse_ff) begin
                        pulse_in = 1'b0;
                     end else begin
                        cur_pos_in    = cur_pos_ff + (dir_ff ? POSITION_BITS'(1) : '1);
                        ramp_index_in = ramp_index_ff + QW'(1);
                        steps_left_in = steps_left_ff - POSITION_BITS'(1);
                        if (steps_left_ff == POSITION_BITS'(1)) begin
                           state_in = stg_pkg::S_PHASE;
                        end else begin
                           state_in = stg_pkg::S_LOAD;
                        end
                     end
                  end else begin
                     timer_in = tsum[DELAY_BITS-1:0];
                  end
               end
            end
         end

         stg_pkg::S_CMD: begin
            cruise_in  = total;
            quarter_in = total[POSITION_BITS-1:2];
            state_in   = stg_pkg::S_CMD2;
         end

         stg_pkg::S_CMD2: begin
            // Cruise covers what the two ramps leave
            if (ramp_ff) begin
               cruise_in = cruise_ff - POSITION_BITS'({quarter_ff, 1'b0});
            end
            state_in = stg_pkg::S_PHASE;
         end

         stg_pkg::S_PHASE: begin
            if (phase_end) begin
               phase_in      = stg_pkg::PH_IDLE;
               pulse_in      = 1'b0;
               steps_left_in = '0;
               state_in      = stg_pkg::S_FINISH;
            end else begin
               phase_in = phase_next;
               // Skip phases without steps
               if (phase_count != '0) begin
                  steps_left_in = phase_count;
                  ramp_index_in = '0;
                  state_in      = stg_pkg::S_LOAD;
               end
            end
         end

         stg_pkg::S_LOAD: begin
            if (phase_ff == stg_pkg::PH_ACCEL || phase_ff == stg_pkg::PH_DECEL) begin
               numer_in   = (phase_ff == stg_pkg::PH_ACCEL) ? ramp_index_ff
                                                            : (quarter_ff - ramp_index_ff);
               mult_in    = max_speed_ff;
               rem_in     = '0;
               speed_in   = '0;
               bit_cnt_in = stg_pkg::SCALE_LAST;
               state_in   = stg_pkg::S_SCALE;
            end else begin
               speed_in = ramp_ff ? max_speed_ff : const_speed_ff;
               state_in = stg_pkg::S_DIVSET;
            end
         end

         stg_pkg::S_SCALE: begin
            rem_in   = srem_new[QW-1:0];
            speed_in = {speed_ff[SPEED_W-2:0], 1'b0} + SPEED_W'(sdigit);
            mult_in  = {mult_ff[SPEED_W-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = stg_pkg::S_DIVSET;
            end else begin
               bit_cnt_in = bit_cnt_ff - stg_pkg::CNT_BITS'(1);
            end
         end

         stg_pkg::S_DIVSET: begin
            // Zero speed takes the longest half-period
            if (speed_ff == '0) begin
               period_in = max_delay_ff;
               timer_in  = '0;
               pulse_in  = 1'b1;
               state_in  = stg_pkg::S_FINISH;
            end else begin
               div_in     = stg_pkg::TICKS_PER_SECOND;
               hrem_in    = '0;
               bit_cnt_in = stg_pkg::DIV_LAST;
               state_in   = stg_pkg::S_DIV;
            end
         end

         stg_pkg::S_DIV: begin
            hrem_in = hrem_new[SPEED_W-1:0];
            div_in  = quotient;
            if (bit_cnt_ff == '0) begin
               period_in = half_sat;
               timer_in  = '0;
               pulse_in  = 1'b1;
               state_in  = stg_pkg::S_FINISH;
            end else begin
               bit_cnt_in = bit_cnt_ff - stg_pkg::CNT_BITS'(1);
            end
         end

         stg_pkg::S_FINISH: begin
            // Hold until the result register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[0]    = pulse_ff;
               rsp_data_in[1]    = dir_ff;
               rsp_data_in[33:2] = pos_wide[stg_pkg::TARGET_BITS-1:0];
               rsp_data_in[34]   = (phase_ff != stg_pkg::PH_IDLE);
               rsp_data_in[35]   = acc_ff;
               state_in = stg_pkg::S_READY;
            end
         end

         default: begin
            state_in = stg_pkg::S_READY;
         end
      endcase
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= stg_pkg::S_READY;
         phase_ff       <= stg_pkg::PH_IDLE;
         pulse_ff       <= 1'b0;
         dir_ff         <= 1'b0;
         ramp_ff        <= 1'b0;
         acc_ff         <= 1'b0;
         cur_pos_ff     <= '0;
         goal_ff        <= '0;
         steps_left_ff  <= '0;
         cruise_ff      <= '0;
         ramp_index_ff  <= '0;
         quarter_ff     <= '0;
         timer_ff       <= '0;
         period_ff      <= DELAY_BITS'(stg_pkg::RESET_MAX_DELAY);
         max_speed_ff   <= stg_pkg::RESET_MAX_SPEED;
         const_speed_ff <= stg_pkg::RESET_CONST_SPEED;
         max_delay_ff   <= DELAY_BITS'(stg_pkg::RESET_MAX_DELAY);
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         pulse_ff       <= pulse_in;
         dir_ff         <= dir_in;
         ramp_ff        <= ramp_in;
         acc_ff         <= acc_in;
         cur_pos_ff     <= cur_pos_in;
         goal_ff        <= goal_in;
         steps_left_ff  <= steps_left_in;
         cruise_ff      <= cruise_in;
         ramp_index_ff  <= ramp_index_in;
         quarter_ff     <= quarter_in;
         timer_ff       <= timer_in;
         period_ff      <= period_in;
         max_speed_ff   <= max_speed_in;
         const_speed_ff <= const_speed_in;
         max_delay_ff   <= max_delay_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Serial unit and result payload registers
   always_ff @(posedge clock) begin
      bit_cnt_ff  <= bit_cnt_in;
      mult_ff     <= mult_in;
      numer_ff    <= numer_in;
      rem_ff      <= rem_in;
      speed_ff    <= speed_in;
      div_ff      <= div_in;
      hrem_ff     <= hrem_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[sim/stepper_trapezoid_step_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper trapezoidal step generator testbench
// Sends tick and move requests, writes the speed and delay registers between
// phases, and checks every result against a motion profile model kept here.
// It starts with a short directed table, then runs phases of random moves
// under several register settings, and ends with a move to a far target.
// ----------------------------------------------------------------------------
module stepper_trapezoid_step_generator_tb;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 60;
   localparam int PLAN_ROWS    = 12;
   localparam int RANDOM_PHASES = 6;
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_MOVE = 1'b1;
   localparam logic [stg_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;

   // One result, laid out as rsp_tdata[35:0] from bit 35 down
   typedef struct packed {
      logic        accepted;
      logic        busy;
      logic [31:0] position;
      logic        dir;
      logic        pulse;
   } motion_levels_type;

   // One row of the directed table
   typedef struct {
      logic              kind;
      logic [31:0]       target;
      logic              ramped;
      int                count;
      logic              typed;
      motion_levels_type levels;
   } plan_row_type;

   logic                                 clock;
   logic                                 reset      = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [stg_pkg::REQ_TDATA_BITS-1:0]   req_tdata  = '0;
   logic                                 req_tuser  = 1'b0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [stg_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata;
   logic                                 csr_valid  = 1'b0;
   logic                                 csr_ready;
   logic [stg_pkg::CSR_INDEX_BITS-1:0]   csr_index  = stg_pkg::CSR_MAX_SPEED;
   logic [stg_pkg::CSR_DATA_BITS-1:0]    csr_data   = '0;

   // Motion model state
   logic [15:0]            cruise_speed, flat_speed;
   logic [23:0]            delay_cap;
   logic [31:0]            pos_now, pos_goal, steps_left, ramp_step;
   logic [29:0]            quarter;
   stg_pkg::stg_phase_type phase_now;
   logic [23:0]            tick_count, half_ticks;
   logic                   pulse_on, heading_cw, trapezoid;

   motion_levels_type expected_levels[$];
   plan_row_type      plan[PLAN_ROWS];

   int unsigned mismatch_count = 0;
   int unsigned request_count  = 0;
   int unsigned moves_taken    = 0;
   int unsigned steps_made     = 0;
   int unsigned settings_count = 0;
   int unsigned cycle_count    = 0;
   logic        calm           = 1'b0;

   stepper_trapezoid_step_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Motion model
   // ---------------------------------------------------------------------

   // Half-period in ticks for a speed, capped at the delay limit
   function automatic logic [23:0] half_for_speed(input logic [31:0] speed);
      logic [31:0] ticks;
      if (speed == 0) return delay_cap;
      ticks = {12'd0, stg_pkg::TICKS_PER_SECOND} / speed;
      return (ticks > {8'd0, delay_cap}) ? delay_cap : ticks[23:0];
   endfunction

   // floor(cruise_speed * n / q)
   function automatic logic [31:0] ramp_speed(input logic [31:0] n, input logic [31:0] q);
      logic [63:0] product;
      product = {48'd0, cruise_speed} * {32'd0, n};
      return 32'(product / {32'd0, q});
   endfunction

   function automatic logic [31:0] distance_left();
      return heading_cw ? pos_goal - pos_now : pos_now - pos_goal;
   endfunction

   // Start a new step: pick its speed and raise the pulse
   function automatic void start_step();
      logic [31:0] speed;
      case (phase_now)
         stg_pkg::PH_ACCEL: speed = ramp_speed(ramp_step, {2'd0, quarter});
         stg_pkg::PH_DECEL: speed = ramp_speed({2'd0, quarter} - ramp_step, {2'd0, quarter});
         default:  speed = trapezoid ? {16'd0, cruise_speed} : {16'd0, flat_speed};
      endcase
      half_ticks = half_for_speed(speed);
      tick_count = '0;
      pulse_on   = 1'b1;
   endfunction

   // Advance through the profile phases, skipping empty ones
   function automatic void enter_next_phase();
      logic [31:0] count;
      count = '0;
      do begin
         if (phase_now == stg_pkg::PH_IDLE) begin
            phase_now = trapezoid ? stg_pkg::PH_ACCEL : stg_pkg::PH_CRUISE;
            count = trapezoid ? {2'd0, quarter} : distance_left();
         end else if (phase_now == stg_pkg::PH_ACCEL) begin
            phase_now = stg_pkg::PH_CRUISE;
            count = distance_left() - {2'd0, quarter};
         end else if (phase_now == stg_pkg::PH_CRUISE && trapezoid) begin
            phase_now = stg_pkg::PH_DECEL;
            count = {2'd0, quarter};
         end else begin
            phase_now  = stg_pkg::PH_IDLE;
            pulse_on   = 1'b0;
            steps_left = '0;
            return;
         end
      end while (count == 0);
      steps_left = count;
      ramp_step  = '0;
      start_step();
   endfunction

   // Apply one request and return the levels that follow it
   function automatic motion_levels_type apply_request(input logic kind,
                                                       input logic [31:0] target,
                                                       input logic ramped);
      motion_levels_type levels;
      logic taken;
      taken = 1'b0;
      if (kind == KIND_MOVE) begin
         if (phase_now == stg_pkg::PH_IDLE) begin
            taken      = 1'b1;
            heading_cw = $signed(target) > $signed(pos_now);
            pos_goal   = target;
            trapezoid  = ramped;
            quarter    = 30'(distance_left() >> 2);
            moves_taken++;
            enter_next_phase();
         end
      end else if (phase_now != stg_pkg::PH_IDLE) begin
         tick_count++;
         if (tick_count >= half_ticks) begin
            tick_count = '0;
            if (pulse_on) begin
               pulse_on = 1'b0;
            end else begin
               pos_now = heading_cw ? pos_now + 32'd1 : pos_now - 32'd1;
               ramp_step++;
               steps_left--;
               steps_made++;
               if (steps_left == 0) enter_next_phase();
               else start_step();
            end
         end
      end
      levels.accepted = taken;
      levels.busy     = phase_now != stg_pkg::PH_IDLE;
      levels.position = pos_now;
      levels.dir      = heading_cw;
      levels.pulse    = pulse_on;
      return levels;
   endfunction

   // ---------------------------------------------------------------------
   // Request and register drivers
   // ---------------------------------------------------------------------

   // Offer one request, hold it until taken, then record what should come back
   task automatic send_request(input logic kind, input logic [31:0] target, input logic ramped,
                               input logic typed, input motion_levels_type typed_levels);
      motion_levels_type levels;
      if (!calm && $urandom_range(0, 99) < 7) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 50);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, ramped, target};
      do @(posedge clock); while (!req_tready);
      levels = apply_request(kind, target, ramped);
      expected_levels.push_back(typed ? typed_levels : levels);
      request_count++;
   endtask

   task automatic send_tick();
      send_request(KIND_TICK, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   task automatic send_move(input logic [31:0] target, input logic ramped);
      send_request(KIND_MOVE, target, ramped, 1'b0, '0);
   endtask

   // Hold the sender until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
   endtask

   // Write one register; valid stays high for a following write
   task automatic write_register(input logic [stg_pkg::CSR_INDEX_BITS-1:0] index,
                                 input logic [stg_pkg::CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         stg_pkg::CSR_MAX_SPEED:   cruise_speed = value[15:0];
         stg_pkg::CSR_CONST_SPEED: flat_speed   = value[15:0];
         stg_pkg::CSR_MAX_DELAY:   delay_cap    = value;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [15:0] max_spd, input logic [15:0] const_spd,
                                input logic [23:0] delay_lim, input logic stray_write);
      drain_results();
      write_register(stg_pkg::CSR_MAX_SPEED, {8'd0, max_spd});
      write_register(stg_pkg::CSR_CONST_SPEED, {8'd0, const_spd});
      write_register(stg_pkg::CSR_MAX_DELAY, delay_lim);
      if (stray_write) write_register(CSR_UNUSED, stg_pkg::CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: stall at random except in calm stretches
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= calm || ($urandom_range(0, 99) >= 7);
   end

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      motion_levels_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[35:0];
         if (expected_levels.size() == 0) begin
            $display("%0t: result %h expected none, got one", $time, got);
            mismatch_count++;
         end else begin
            want = expected_levels.pop_front();
            report_field("step_level", {31'd0, want.pulse}, {31'd0, got.pulse});
            report_field("dir_level", {31'd0, want.dir}, {31'd0, got.dir});
            report_field("position", want.position, got.position);
            report_field("busy", {31'd0, want.busy}, {31'd0, got.busy});
            report_field("accepted", {31'd0, want.accepted}, {31'd0, got.accepted});
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d results outstanding", $time, expected_levels.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   initial begin
      logic [15:0] max_spd, const_spd;
      logic [23:0] delay_lim;
      logic [31:0] far_target;
      int          reach, budget, quota, pick, offset;

      // Register defaults and idle state
      cruise_speed = stg_pkg::RESET_MAX_SPEED;
      flat_speed   = stg_pkg::RESET_CONST_SPEED;
      delay_cap    = stg_pkg::RESET_MAX_DELAY[23:0];
      pos_now      = '0;
      pos_goal     = '0;
      steps_left   = '0;
      ramp_step    = '0;
      quarter      = '0;
      phase_now    = stg_pkg::PH_IDLE;
      tick_count   = '0;
      half_ticks   = delay_cap;
      pulse_on     = 1'b0;
      heading_cw   = 1'b0;
      trapezoid    = 1'b0;

      // Directed table: with a one-tick half-period every step takes two ticks
      plan = '{
         '{KIND_TICK, 32'd0,          1'b0, 1, 1'b1, '{1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
         '{KIND_MOVE, 32'd0,          1'b0, 1, 1'b1, '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0}},
         '{KIND_MOVE, 32'd0,          1'b1, 1, 1'b1, '{1'b1, 1'b0, 32'd0, 1'b0, 1'b0}},
         '{KIND_MOVE, 32'd2,          1'b0, 1, 1'b0, '0},
         '{KIND_MOVE, 32'h8000_0000,  1'b1, 1, 1'b1, '{1'b0, 1'b1, 32'd0, 1'b1, 1'b1}},
         '{KIND_TICK, 32'hFFFF_FFFF,  1'b1, 4, 1'b0, '0},
         '{KIND_MOVE, 32'd2,          1'b1, 1, 1'b1, '{1'b1, 1'b0, 32'd2, 1'b0, 1'b0}},
         '{KIND_MOVE, 32'hFFFF_FFFE,  1'b1, 1, 1'b0, '0},
         '{KIND_MOVE, 32'h7FFF_FFFF,  1'b0, 1, 1'b0, '0},
         '{KIND_TICK, 32'd0,          1'b0, 8, 1'b0, '0},
         '{KIND_MOVE, 32'hFFFF_FFFD,  1'b0, 1, 1'b0, '0},
         '{KIND_TICK, 32'd0,          1'b0, 2, 1'b0, '0}
      };

      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the fastest settings
      load_settings(16'hFFFF, 16'hFFFF, 24'd1, 1'b0);
      foreach (plan[r])
         repeat (plan[r].count)
            send_request(plan[r].kind, plan[r].target, plan[r].ramped,
                         plan[r].typed, plan[r].levels);

      // Random phases, one register setting each
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         calm = 1'b0;
         case (ph)
            0: begin
               max_spd = 16'hFFFF; const_spd = 16'hFFFF; delay_lim = 24'd1;
               reach = 12; quota = 180;
            end
            1: begin
               max_spd   = 16'($urandom_range(40000, 65535));
               const_spd = 16'($urandom_range(40000, 65535));
               delay_lim = 24'd40; reach = 9; quota = 150;
            end
            2: begin
               max_spd = 16'd1; const_spd = 16'd1; delay_lim = 24'd2;
               reach = 10; quota = 150; calm = 1'b1;
            end
            3: begin
               max_spd = 16'hFFFF; const_spd = 16'hFFFF; delay_lim = 24'hFF_FFFF;
               reach = 3; quota = 120;
            end
            4: begin
               max_spd   = 16'($urandom_range(1, 65535));
               const_spd = 16'($urandom_range(1, 65535));
               delay_lim = 24'($urandom_range(1, 6)); reach = 16; quota = 180;
            end
            default: begin
               max_spd   = 16'hFFFF;
               const_spd = 16'($urandom_range(20000, 65535));
               delay_lim = 24'd70; reach = 10; quota = 150;
            end
         endcase
         load_settings(max_spd, const_spd, delay_lim, ph == 4);

         budget = 0;
         while (budget < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
               // idle tick
               send_tick();
            end else if (pick < 12) begin
               // move to where it already stands
               send_move(pos_now, 1'($urandom_range(0, 1)));
               budget++;
            end else begin
               // a full move, ticked to the end, with stray commands mixed in
               offset = int'($urandom_range(0, 2 * reach)) - reach;
               send_move(pos_now + 32'(offset), 1'($urandom_range(0, 1)));
               budget++;
               while (phase_now != stg_pkg::PH_IDLE) begin
                  if ($urandom_range(0, 99) < 6) begin
                     send_move($urandom, 1'($urandom_range(0, 1)));
                  end else begin
                     send_tick();
                     budget++;
                  end
               end
            end
         end
      end

      // Far target: a ramp of enormous length that stays in the first steps
      calm = 1'b0;
      load_settings(16'hFFFF, 16'hFFFF, 24'd5, 1'b0);
      far_target = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      send_move(far_target, 1'b1);
      repeat (80) begin
         if ($urandom_range(0, 99) < 10) send_move($urandom, 1'($urandom_range(0, 1)));
         else send_tick();
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests under %0d register settings: %0d moves taken, %0d steps made",
               request_count, settings_count, moves_taken, steps_made);
      $display("Final position %0d, %0d field mismatches", $signed(pos_now), mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[stepper_trapezoid_step_generator.f]
design/stg_pkg.sv
design/stepper_trapezoid_step_generator.sv
sim/stepper_trapezoid_step_generator_tb.sv
